// ===== hw/rtl/pcsc_pkg.sv =====
`timescale 1ns / 1ps
package pcsc_pkg;
    localparam int MemWords = 1024;
    localparam int MemAw = $clog2(MemWords);

    typedef enum logic [1:0] {
        MODE_EXEC = 2'd0,
        MODE_HOST = 2'd1,
        MODE_PTRS = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        FN_PFIX = 4'h0, FN_NFIX = 4'h1, FN_OPR = 4'h2, FN_LDL = 4'h3,
        FN_STL = 4'h4, FN_LDLP = 4'h5, FN_LDC = 4'h6, FN_ADC = 4'h7,
        FN_EQC = 4'h8, FN_J = 4'h9, FN_CJ = 4'hA, FN_LDNL = 4'hB,
        FN_STNL = 4'hC, FN_LDNLP = 4'hD, FN_CALL = 4'hE, FN_AJW = 4'hF
    } t_fn;

    localparam logic [31:0] OP_REV = 32'h0;
    localparam logic [31:0] OP_EQZ = 32'h1;
    localparam logic [31:0] OP_GT  = 32'h2;
    localparam logic [31:0] OP_AND = 32'h3;
    localparam logic [31:0] OP_OR  = 32'h4;
    localparam logic [31:0] OP_XOR = 32'h5;
    localparam logic [31:0] OP_ADD = 32'h6;
    localparam logic [31:0] OP_SUB = 32'h7;
    localparam logic [31:0] OP_MUL = 32'h8;
    localparam logic [31:0] OP_DIV = 32'h9;
    localparam logic [31:0] OP_MOD = 32'hA;
    localparam logic [31:0] OP_SHL = 32'hB;
    localparam logic [31:0] OP_SHR = 32'hC;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_MUL, ST_DIV, ST_MEM, ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  instr_byte;
        logic [31:0] host_addr;
        logic [31:0] host_data;
    } t_in;

    typedef struct packed {
        logic [31:0] reg_a;
        logic [31:0] reg_b;
        logic [31:0] reg_c;
        logic [31:0] operand_reg;
        logic [31:0] iptr;
        logic [31:0] wptr;
        logic        error;
    } t_out;

    // Start, busy and done of the iterative divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

    function automatic logic [MemAw-1:0] word_index(input logic [31:0] addr);
        return addr[MemAw+1:2];
    endfunction
endpackage

// ===== hw/rtl/pcsc_if.sv =====
`timescale 1ns / 1ps
interface pcsc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pcsc_ram.sv =====
`timescale 1ns / 1ps
module pcsc_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/pcsc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle.
module pcsc_div import pcsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output t_div_ctl    o_ctl,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [32:0] w_trial;

    assign w_trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_den};

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = 6'd0;
            n_busy = 1'b1;
            n_quo = i_num;
            n_rem = '0;
        end else if (r_busy) begin
            if (w_trial[32]) begin
                n_rem = {r_rem[31:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[30:0], 1'b1};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quo = r_quo;
    assign o_rem = r_rem[31:0];

    always @(posedge i_clk) begin
        if (i_rst_n && r_done) begin
            assert (!r_busy) else $error("divider done while busy");
        end
    end
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == 6'd31) |=> r_done)
        else $error("divider did not finish after 32 steps");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == 6'd0))
        else $error("divider start lost");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !r_done)
        else $error("divider done without work");
endmodule

// ===== hw/rtl/prefix_coded_stack_cpu_step.sv =====
`timescale 1ns / 1ps
// One item per step; items are taken one at a time. A step reads the word
// memory once through its synchronous read port and writes it only for a
// store or host write. Items pass ST_DECODE, ST_MEM, ST_DONE; mul adds ST_MUL
// for the registered product, div or mod by nonzero adds ST_DIV for the
// one-bit-per-cycle divider. The result register holds the item until taken.
// A step that finishes while the previous result is still untaken waits in
// its last state until that result is taken. The next item is accepted from
// the cycle after the result is loaded, whether or not it has been taken.
// Reads of memory words never written return unspecified data.
module prefix_coded_stack_cpu_step import pcsc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    pcsc_if.sink   i_in,
    pcsc_if.source o_out
);
    t_state r_state, n_state;
    t_in    r_in;
    logic [31:0] r_a, r_b, r_c, r_o, r_ip, r_wp;
    logic [31:0] n_a, n_b, n_c, n_o, n_ip, n_wp;
    logic        n_err;
    t_out        r_res;
    logic        r_res_err;
    logic        r_out_valid;
    logic [31:0] r_prod, r_prod_hi;
    logic [1:0]  r_mcnt;

    logic [3:0]  w_fn;
    logic [31:0] w_oper, w_addr;
    logic        w_mem_we;
    logic [31:0] w_mem_wdata;
    logic [MemAw-1:0] w_mem_waddr;
    logic [31:0] w_rdata;
    logic        w_div_start;
    t_div_ctl    w_div;
    logic [31:0] w_quo, w_rem;
    logic        w_accept, w_commit;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_fn = r_in.instr_byte[7:4];
    assign w_oper = r_o | {28'd0, r_in.instr_byte[3:0]};
    assign w_addr = ((w_fn == FN_LDL || w_fn == FN_STL) ? r_wp : r_a) + (w_oper << 2);

    pcsc_ram #(.Width(32), .Depth(MemWords)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_mem_waddr),
        .i_wdata(w_mem_wdata),
        .i_raddr(word_index(w_addr)),
        .o_rdata(w_rdata)
    );

    pcsc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_b),
        .i_den  (r_a),
        .o_ctl  (w_div),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_DECODE;
            ST_DECODE: begin
                if (r_in.mode == MODE_EXEC && w_fn == FN_OPR && w_oper == OP_MUL) begin
                    n_state = ST_MUL;
                end else if (r_in.mode == MODE_EXEC && w_fn == FN_OPR && r_a != '0
                             && (w_oper == OP_DIV || w_oper == OP_MOD)) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_MEM;
                end
            end
            ST_MUL:    if (r_mcnt == 2'd1) n_state = ST_MEM;
            ST_DIV:    if (w_div.done) n_state = ST_MEM;
            ST_MEM:    n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_div_start = (r_state == ST_DECODE) && (n_state == ST_DIV);
        w_commit = (r_state == ST_MEM);
    end

    // Step evaluation; in ST_MEM the read data of the addressed word is valid.
    always_comb begin
        logic [31:0] bin;
        logic        bin_ok;
        n_a = r_a; n_b = r_b; n_c = r_c; n_o = '0;
        n_ip = r_ip + 32'd1; n_wp = r_wp; n_err = 1'b0;
        w_mem_we = 1'b0;
        w_mem_waddr = word_index(w_addr);
        w_mem_wdata = r_a;
        bin = '0;
        bin_ok = 1'b1;
        case (w_oper)
            OP_GT:  bin = {31'd0, r_b > r_a};
            OP_AND: bin = r_b & r_a;
            OP_OR:  bin = r_b | r_a;
            OP_XOR: bin = r_b ^ r_a;
            OP_ADD: bin = r_b + r_a;
            OP_SUB: bin = r_b - r_a;
            OP_MUL: bin = r_prod;
            OP_DIV: begin bin = w_quo; bin_ok = (r_a != '0); end
            OP_MOD: begin bin = w_rem; bin_ok = (r_a != '0); end
            OP_SHL: bin = (r_a >= 32'd32) ? '0 : (r_b << r_a[4:0]);
            default: bin = (r_a >= 32'd32) ? '0 : (r_b >> r_a[4:0]);
        endcase
        case (t_mode'(r_in.mode))
            MODE_EXEC: begin
                case (t_fn'(w_fn))
                    FN_PFIX: n_o = w_oper << 4;
                    FN_NFIX: n_o = (~w_oper) << 4;
                    FN_OPR: begin
                        if (w_oper == OP_REV) begin
                            n_a = r_b; n_b = r_a;
                        end else if (w_oper == OP_EQZ) begin
                            n_a = {31'd0, r_a == '0};
                        end else if (w_oper <= OP_SHR) begin
                            n_err = !bin_ok;
                            n_a = bin; n_b = r_c;
                        end
                    end
                    FN_LDL: begin
                        n_err = (r_wp[1:0] != 2'd0);
                        n_c = r_b; n_b = r_a; n_a = w_rdata;
                    end
                    FN_STL: begin
                        n_err = (r_wp[1:0] != 2'd0);
                        w_mem_we = w_commit && !n_err;
                        n_a = r_b; n_b = r_c;
                    end
                    FN_LDLP: begin n_c = r_b; n_b = r_a; n_a = r_wp + (w_oper << 2); end
                    FN_LDC:  begin n_c = r_b; n_b = r_a; n_a = w_oper; end
                    FN_ADC:  n_a = r_a + w_oper;
                    FN_EQC:  n_a = {31'd0, r_a == w_oper};
                    FN_J:    n_ip = r_ip + 32'd1 + w_oper;
                    FN_CJ: begin
                        if (r_a == '0) n_ip = r_ip + 32'd1 + w_oper;
                        else begin n_a = r_b; n_b = r_c; end
                    end
                    FN_LDNL: begin
                        n_err = (r_a[1:0] != 2'd0);
                        n_a = w_rdata;
                    end
                    FN_STNL: begin
                        n_err = (r_a[1:0] != 2'd0);
                        w_mem_wdata = r_b;
                        w_mem_we = w_commit && !n_err;
                        n_a = r_c; n_b = r_c;
                    end
                    FN_LDNLP: begin
                        n_err = (r_a[1:0] != 2'd0);
                        n_a = w_addr;
                    end
                    FN_CALL: n_err = 1'b1;
                    default: n_wp = r_wp + (w_oper << 2);
                endcase
            end
            MODE_HOST: begin
                n_a = r_a; n_b = r_b; n_c = r_c; n_o = r_o; n_ip = r_ip;
                n_err = (r_in.host_addr[1:0] != 2'd0);
                w_mem_waddr = word_index(r_in.host_addr);
                w_mem_wdata = r_in.host_data;
                w_mem_we = w_commit && !n_err;
            end
            MODE_PTRS: begin
                n_o = r_o; n_ip = r_in.host_addr; n_wp = r_in.host_data;
            end
            default: begin
                n_o = r_o; n_ip = r_ip;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_a <= '0; r_b <= '0; r_c <= '0;
            r_o <= '0; r_ip <= '0; r_wp <= '0;
            r_mcnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_mcnt <= (r_state == ST_MUL) ? r_mcnt + 2'd1 : 2'd0;
            if (w_commit) begin
                if (!n_err) begin
                    r_a <= n_a; r_b <= n_b; r_c <= n_c;
                    r_o <= n_o; r_ip <= n_ip; r_wp <= n_wp;
                end
            end
        end
        if (w_accept) r_in <= i_in.data;
        // Product split into two 16-bit halves of A; partial products are registered, then summed.
        if (r_state == ST_MUL && r_mcnt == 2'd0) begin
            r_prod <= r_b * {16'd0, r_a[15:0]};
            r_prod_hi <= r_b * {16'd0, r_a[31:16]};
        end
        if (r_state == ST_MUL && r_mcnt == 2'd1) begin
            r_prod <= r_prod + {r_prod_hi[15:0], 16'd0};
        end
        if (r_state == ST_DONE && (!r_out_valid || o_out.ready)) begin
            r_res <= '{reg_a: r_a, reg_b: r_b, reg_c: r_c, operand_reg: r_o,
                       iptr: r_ip, wptr: r_wp, error: r_res_err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) r_res_err <= n_err;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data = r_res;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DECODE))
        else $error("accepted item did not start decode");
    a_no_write_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we) |-> (r_state == ST_MEM && !n_err))
        else $error("memory written outside commit");
    a_div_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_a != '0))
        else $error("divider started on zero");
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && n_err) |=> $stable(r_a) && $stable(r_ip))
        else $error("state changed on refused step");
endmodule

// ===== tb/tb_prefix_coded_stack_cpu_step.sv =====
`timescale 1ns / 1ps
module tb_prefix_coded_stack_cpu_step;
    import pcsc_pkg::*;

    localparam int CycleLimit = 400000;

    // Expected step results, oldest first, with the machine state they imply.
    class step_scoreboard;
        logic [31:0] a, b, c, opnd, ip, wp;
        logic [31:0] mem [MemWords];
        bit          written [MemWords];
        t_out        pending[$];
        int          errors;

        function void clear();
            a = 0; b = 0; c = 0; opnd = 0; ip = 0; wp = 0;
            foreach (written[i]) written[i] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function automatic logic [31:0] rd(input logic [31:0] addr);
            return mem[addr[MemAw+1:2]];
        endfunction

        function automatic void wr(input logic [31:0] addr, input logic [31:0] d);
            mem[addr[MemAw+1:2]] = d;
            written[addr[MemAw+1:2]] = 1;
        endfunction

        function automatic bit can_read(input logic [31:0] addr);
            return written[addr[MemAw+1:2]];
        endfunction

        // Runs one instruction byte; returns 1 when the step is refused.
        function automatic bit execute(input logic [7:0] ib);
            t_fn         fn;
            logic [31:0] oper, na, nb, nc, nip, nwp, no, r;
            fn = t_fn'(ib[7:4]);
            oper = opnd | {28'd0, ib[3:0]};
            na = a; nb = b; nc = c; nip = ip + 1; nwp = wp; no = 0;
            case (fn)
                FN_PFIX: no = oper << 4;
                FN_NFIX: no = (~oper) << 4;
                FN_OPR: begin
                    if (oper == OP_REV) begin
                        na = b; nb = a;
                    end else if (oper == OP_EQZ) begin
                        na = {31'd0, a == 0};
                    end else if (oper <= OP_SHR) begin
                        case (oper)
                            OP_GT:  r = {31'd0, b > a};
                            OP_AND: r = b & a;
                            OP_OR:  r = b | a;
                            OP_XOR: r = b ^ a;
                            OP_ADD: r = b + a;
                            OP_SUB: r = b - a;
                            OP_MUL: r = b * a;
                            OP_DIV: begin
                                if (a == 0) return 1;
                                r = b / a;
                            end
                            OP_MOD: begin
                                if (a == 0) return 1;
                                r = b % a;
                            end
                            OP_SHL: r = (a >= 32) ? 0 : b << a[4:0];
                            default: r = (a >= 32) ? 0 : b >> a[4:0];
                        endcase
                        na = r; nb = c;
                    end
                end
                FN_LDL: begin
                    if (wp[1:0] != 0) return 1;
                    nc = b; nb = a; na = rd(wp + oper * 4);
                end
                FN_STL: begin
                    if (wp[1:0] != 0) return 1;
                    wr(wp + oper * 4, a);
                    na = b; nb = c;
                end
                FN_LDLP: begin
                    nc = b; nb = a; na = wp + oper * 4;
                end
                FN_LDC: begin
                    nc = b; nb = a; na = oper;
                end
                FN_ADC: na = a + oper;
                FN_EQC: na = {31'd0, a == oper};
                FN_J: nip = ip + 1 + oper;
                FN_CJ: begin
                    if (a == 0) nip = ip + 1 + oper;
                    else begin
                        na = b; nb = c;
                    end
                end
                FN_LDNL: begin
                    if (a[1:0] != 0) return 1;
                    na = rd(a + oper * 4);
                end
                FN_STNL: begin
                    if (a[1:0] != 0) return 1;
                    wr(a + oper * 4, b);
                    na = c; nb = c;
                end
                FN_LDNLP: begin
                    if (a[1:0] != 0) return 1;
                    na = a + oper * 4;
                end
                FN_CALL: return 1;
                default: nwp = wp + oper * 4;
            endcase
            a = na; b = nb; c = nc; opnd = no; ip = nip; wp = nwp;
            return 0;
        endfunction

        function void note_input(input t_in it);
            t_out e;
            bit   err;
            err = 0;
            case (t_mode'(it.mode))
                MODE_EXEC: err = execute(it.instr_byte);
                MODE_HOST: begin
                    if (it.host_addr[1:0] != 0) err = 1;
                    else wr(it.host_addr, it.host_data);
                end
                MODE_PTRS: begin
                    ip = it.host_addr; wp = it.host_data;
                end
                default: ;
            endcase
            e = '{a, b, c, opnd, ip, wp, err};
            pending.push_back(e);
        endfunction

        function void check_result(input t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: result mismatch expected %p actual %p", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pcsc_if #(.T(t_in))  in_ch ();
    pcsc_if #(.T(t_out)) out_ch ();

    prefix_coded_stack_cpu_step dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source)
    );

    step_scoreboard steps;
    int             cycles;
    bit             sending_done;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Valid stays high between back-to-back items and drops only for a gap.
    task automatic send(input t_in it);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        steps.note_input(it);
    endtask

    task automatic exec(input logic [7:0] ib);
        t_in it;
        it = '{MODE_EXEC, ib, $urandom, $urandom};
        send(it);
    endtask

    task automatic host_write(input logic [31:0] addr, input logic [31:0] d);
        t_in it;
        it = '{MODE_HOST, 8'($urandom), addr, d};
        send(it);
    endtask

    task automatic set_ptrs(input logic [31:0] ip, input logic [31:0] wp);
        t_in it;
        it = '{MODE_PTRS, 8'($urandom), ip, wp};
        send(it);
    endtask

    // Pushes a full 32-bit constant through a prefix chain and ldc.
    task automatic load_const(input logic [31:0] v);
        for (int i = 7; i > 0; i--) exec({FN_PFIX, v[i*4 +: 4]});
        exec({FN_LDC, v[3:0]});
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // Picks an instruction whose memory read, if any, hits a written word.
    task automatic random_exec();
        logic [7:0]  ib;
        logic [31:0] oper;
        t_fn         fn;
        bit          ok;
        ok = 0;
        while (!ok) begin
            ib = 8'($urandom);
            if ($urandom_range(0, 3) == 0) ib = {FN_OPR, 4'($urandom_range(0, 15))};
            fn = t_fn'(ib[7:4]);
            oper = steps.opnd | {28'd0, ib[3:0]};
            ok = 1;
            if (fn == FN_LDL && steps.wp[1:0] == 0)
                ok = steps.can_read(steps.wp + oper * 4);
            if (fn == FN_LDNL && steps.a[1:0] == 0)
                ok = steps.can_read(steps.a + oper * 4);
        end
        exec(ib);
    endtask

    initial begin
        int          p;
        logic [31:0] addr;
        steps = new();
        steps.clear();
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        sending_done = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Fill a small window of words that later loads can read.
        for (int i = 0; i < 64; i++) host_write(i * 4, $urandom);
        host_write(32'hFFFF_FFFC, 32'hFFFF_FFFF);
        host_write(32'h0000_0006, 32'h1234_5678);
        set_ptrs(32'hFFFF_FFFF, 32'h0000_0010);
        load_const(32'hFFFF_FFFF);
        exec({FN_LDC, 4'h0});
        exec({FN_OPR, 4'h9});
        exec({FN_OPR, 4'hA});
        exec({FN_LDC, 4'h5});
        exec({FN_OPR, 4'hB});
        exec({FN_PFIX, 4'h2});
        exec({FN_LDC, 4'h1});
        exec({FN_OPR, 4'hC});
        exec({FN_OPR, 4'hF});
        exec({FN_NFIX, 4'h0});
        exec({FN_ADC, 4'hF});
        exec({FN_CALL, 4'h0});
        exec({FN_CJ, 4'h3});
        exec({FN_EQC, 4'h0});
        exec({FN_CJ, 4'h2});
        exec({FN_LDNL, 4'h0});
        exec({FN_LDLP, 4'h1});
        exec({FN_STNL, 4'h0});
        for (int op = 0; op < 13; op++) begin
            load_const(rand_word());
            exec({FN_OPR, 4'(op)});
        end
        send('{MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});

        for (int n = 0; n < 140; n++) begin
            p = $urandom_range(0, 99);
            if (p < 5) begin
                addr = $urandom_range(0, 63) * 4;
                if ($urandom_range(0, 5) == 0) addr = $urandom;
                host_write(addr, $urandom);
            end else if (p < 10) begin
                set_ptrs($urandom, $urandom_range(0, 3) == 0 ? $urandom
                                                             : $urandom_range(0, 40) * 4);
            end else if (p < 20) begin
                // Aligned word address into the written window.
                load_const($urandom_range(0, 40) * 4);
            end else if (p < 30) begin
                load_const(rand_word());
            end else if (p < 32) begin
                send('{MODE_NONE, 8'($urandom), $urandom, $urandom});
            end else begin
                random_exec();
            end
        end
        in_ch.valid <= 0;
        sending_done = 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 0;
        else out_ch.ready <= ($urandom_range(0, 99) < 70) ||
                             ($urandom_range(0, 99) < 20 && cycles[9]);
        if (i_rst_n && out_ch.valid && out_ch.ready) steps.check_result(out_ch.data);
    end

    initial begin
        @(posedge sending_done);
        while (steps.pending.size() != 0 && cycles < CycleLimit) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (cycles >= CycleLimit) begin
            $display("end of test: mismatches");
        end else if (steps.errors == 0 && steps.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit + 100) begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule
